// File: rtl/framed_packet_parser_checksum_unit_macros.svh
// Assertion macros shared by the frame parser RTL.
// Uses clk_i and rst_ni of the including module.
`ifndef FRAMED_PACKET_PARSER_CHECKSUM_UNIT_MACROS_SVH
`define FRAMED_PACKET_PARSER_CHECKSUM_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define FPPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FPPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fppc_pkg.sv
// Shared types and constants for the framed packet parser.
// No dependencies.
`default_nettype none

package fppc_pkg;

  localparam int unsigned CfgIdxW = 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgHeader = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgUserId = 8'd1;

  localparam logic [7:0] HeaderReset = 8'd165;
  localparam logic [7:0] UserIdReset = 8'd1;

  // event codes
  localparam logic [1:0] EvPayload = 2'd0;
  localparam logic [1:0] EvGood    = 2'd1;
  localparam logic [1:0] EvBad     = 2'd2;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  data_byte;
    logic [15:0] payload_index;
    logic [7:0]  msg_type;
    logic [15:0] msg_id;
    logic [15:0] payload_length;
    logic        frame_end;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/fppc_parser.sv
// Frame parse state machine: consumes one word per accepted input and
// produces at most one result word. Depends on fppc_pkg and the macro header.
`default_nettype none

`include "framed_packet_parser_checksum_unit_macros.svh"

module fppc_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_fire_i,
  input  wire logic [7:0]       rx_byte_i,
  input  wire logic [7:0]       header_value_i,
  input  wire logic [7:0]       user_id_value_i,
  output logic                  res_valid_o,
  output fppc_pkg::result_t     res_o
);

  localparam logic [2:0] PhHeader = 3'd0;
  localparam logic [2:0] PhUser   = 3'd1;
  localparam logic [2:0] PhType   = 3'd2;
  localparam logic [2:0] PhLength = 3'd3;
  localparam logic [2:0] PhId     = 3'd4;
  localparam logic [2:0] PhData   = 3'd5;
  localparam logic [2:0] PhCheck  = 3'd6;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] len_q, len_d;
  logic [15:0] id_q, id_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] cnt_inc;
  logic [7:0]  sum_add;
  logic [7:0]  expect_sum;

  assign cnt_inc    = cnt_q + 16'd1;
  assign sum_add    = sum_q + rx_byte_i;
  assign expect_sum = 8'd0 - sum_q;

  always_comb begin
    phase_d     = phase_q;
    sum_d       = sum_q;
    type_d      = type_q;
    len_d       = len_q;
    id_d        = id_q;
    cnt_d       = cnt_q;
    res_valid_o = 1'b0;
    res_o.event_res      = fppc_pkg::EvPayload;
    res_o.data_byte      = 8'd0;
    res_o.payload_index  = 16'd0;
    res_o.msg_type       = type_q;
    res_o.msg_id         = id_q;
    res_o.payload_length = len_q;
    res_o.frame_end      = 1'b0;
    if (in_fire_i) begin
      case (phase_q)
        PhUser: begin
          if (rx_byte_i == user_id_value_i) begin
            sum_d   = sum_add;
            phase_d = PhType;
          end else begin
            phase_d = PhHeader;
            sum_d   = 8'd0;
            type_d  = 8'd0;
            len_d   = 16'd0;
            id_d    = 16'd0;
            cnt_d   = 16'd0;
          end
        end
        PhType: begin
          sum_d   = sum_add;
          type_d  = rx_byte_i;
          cnt_d   = 16'd0;
          phase_d = PhLength;
        end
        PhLength: begin
          sum_d = sum_add;
          if (cnt_q == 16'd0) begin
            len_d = {8'd0, rx_byte_i};
            cnt_d = 16'd1;
          end else begin
            len_d   = {rx_byte_i, len_q[7:0]};
            cnt_d   = 16'd0;
            phase_d = PhId;
          end
        end
        PhId: begin
          sum_d = sum_add;
          if (cnt_q == 16'd0) begin
            id_d  = {8'd0, rx_byte_i};
            cnt_d = 16'd1;
          end else begin
            id_d    = {rx_byte_i, id_q[7:0]};
            cnt_d   = 16'd0;
            // empty payload skips straight to the checksum word
            phase_d = (len_q == 16'd0) ? PhCheck : PhData;
          end
        end
        PhData: begin
          sum_d               = sum_add;
          res_valid_o         = 1'b1;
          res_o.data_byte     = rx_byte_i;
          res_o.payload_index = cnt_q;
          cnt_d               = cnt_inc;
          if (cnt_inc == len_q) begin
            phase_d = PhCheck;
          end
        end
        PhCheck: begin
          res_valid_o     = 1'b1;
          res_o.event_res = (rx_byte_i == expect_sum) ? fppc_pkg::EvGood : fppc_pkg::EvBad;
          res_o.frame_end = 1'b1;
          phase_d = PhHeader;
          sum_d   = 8'd0;
          type_d  = 8'd0;
          len_d   = 16'd0;
          id_d    = 16'd0;
          cnt_d   = 16'd0;
        end
        default: begin
          // hunting; the unused code behaves the same
          if (rx_byte_i == header_value_i) begin
            phase_d = PhUser;
            sum_d   = rx_byte_i;
            type_d  = 8'd0;
            len_d   = 16'd0;
            id_d    = 16'd0;
            cnt_d   = 16'd0;
          end else begin
            phase_d = PhHeader;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      sum_q   <= 8'd0;
      type_q  <= 8'd0;
      len_q   <= 16'd0;
      id_q    <= 16'd0;
      cnt_q   <= 16'd0;
    end else begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      type_q  <= type_d;
      len_q   <= len_d;
      id_q    <= id_d;
      cnt_q   <= cnt_d;
    end
  end

  `FPPC_ASSERT_NOW(a_res_phase, res_valid_o, (phase_q == PhData) || (phase_q == PhCheck), "result outside data or check phase")
  `FPPC_ASSERT_NOW(a_data_in_range, in_fire_i && (phase_q == PhData), cnt_q < len_q, "payload index past declared length")
  `FPPC_ASSERT_NEXT(a_check_clears, in_fire_i && (phase_q == PhCheck), (phase_q == PhHeader) && (sum_q == 8'd0), "frame not cleared after checksum")

endmodule

`default_nettype wire

// File: rtl/fppc_out_queue.sv
// Two-entry result queue: holds the result register and a skid slot so the
// parser keeps accepting while the receiver stalls. Depends on fppc_pkg and the macro header.
`default_nettype none

`include "framed_packet_parser_checksum_unit_macros.svh"

module fppc_out_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire fppc_pkg::result_t push_data_i,
  output logic                   full_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output fppc_pkg::result_t      out_data_o
);

  fppc_pkg::result_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  assign full_o      = (cnt_q == 2'd2);
  assign out_data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  `FPPC_ASSERT_NOW(a_no_overflow, full_o, !push_i, "push into full result queue")
  `FPPC_ASSERT_NEXT(a_cnt_up, push_i && !pop, cnt_q == $past(cnt_q) + 2'd1, "queue count did not rise")
  `FPPC_ASSERT_NEXT(a_cnt_down, pop && !push_i, cnt_q == $past(cnt_q) - 2'd1, "queue count did not fall")

endmodule

`default_nettype wire

// File: rtl/framed_packet_parser_checksum_unit.sv
// Framed serial packet parser with two's-complement checksum, top level.
// Holds the configuration registers; uses fppc_parser and fppc_out_queue.
//
// Usage:
//   Input channel: one received word (rx_byte_i) per handshake, accepted on a
//   rising edge with in_valid_i high and in_stall_o low. The parser hunts for
//   the header word, checks the user id, captures type, length and id, then
//   emits one result per payload word and one verdict on the checksum word.
//   Output channel: result words with out_valid_o, taken when out_stall_i is
//   low. Header, user id, type, length and message id words produce no result.
//   A result is registered in the queue when its input is accepted.
//   Throughput: one word per cycle while in_stall_o is low; the parse state is
//   updated on each accepted word and the result lands in a two-entry queue.
//   Stall: while the receiver stalls, the queue absorbs up to two results;
//   in_stall_o rises only when both entries are occupied.
//   Configuration: cfg_ready_o is always high; index 0 is the header value,
//   index 1 the user id; other indexes are ignored. Write only while idle.
//   Reset: asynchronous, active low; clears the parse state, empties the
//   queue and restores header 165 and user id 1.
`default_nettype none

module framed_packet_parser_checksum_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [7:0]                     rx_byte_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [1:0]                          event_res_o,
  output logic [7:0]                          data_byte_o,
  output logic [15:0]                         payload_index_o,
  output logic [7:0]                          msg_type_o,
  output logic [15:0]                         msg_id_o,
  output logic [15:0]                         payload_length_o,
  output logic                                frame_end_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [fppc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [7:0]                     cfg_data_i
);

  logic [7:0]        header_q, user_id_q;
  logic              in_fire;
  logic              res_valid;
  logic              q_full;
  fppc_pkg::result_t res;
  fppc_pkg::result_t out_res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign in_fire     = in_valid_i && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= fppc_pkg::HeaderReset;
      user_id_q <= fppc_pkg::UserIdReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fppc_pkg::CfgHeader: header_q  <= cfg_data_i;
        fppc_pkg::CfgUserId: user_id_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fppc_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_fire_i       (in_fire),
    .rx_byte_i       (rx_byte_i),
    .header_value_i  (header_q),
    .user_id_value_i (user_id_q),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  fppc_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (q_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign event_res_o      = out_res.event_res;
  assign data_byte_o      = out_res.data_byte;
  assign payload_index_o  = out_res.payload_index;
  assign msg_type_o       = out_res.msg_type;
  assign msg_id_o         = out_res.msg_id;
  assign payload_length_o = out_res.payload_length;
  assign frame_end_o      = out_res.frame_end;

endmodule

`default_nettype wire
